// ===== hdl/wgl_pkg.sv =====
// wgl_pkg: shared types, constants and source-position helpers for the wave grid block
// no dependencies; imported by every module of the block but wgl_ram

package wgl_pkg;

   // default grid geometry
   localparam int GRID_COLS_DEF = 128;
   localparam int GRID_ROWS_DEF = 128;
   localparam int EDGE_BAND_DEF = 8;

   // field widths
   localparam int AMP_W      = 24;
   localparam int PHASE_W    = 16;
   localparam int MASS_W     = 23;
   localparam int COEF_W     = 16;
   localparam int TICK_W     = 32;
   localparam int FUNC_W     = 2;
   localparam int COORD_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   // stencil pipeline length from issue to memory write, plus margin
   localparam int PIPE_DEPTH = 9;

   // register reset values
   localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 16'd1877;
   localparam logic [MASS_W-1:0]  MASS_RST       = 23'd655360;
   localparam logic [COEF_W-1:0]  COUPLING_RST   = 16'd16384;
   localparam logic [COEF_W-1:0]  DAMPING_RST    = 16'd65274;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK,
      FUNC_PULSE,
      FUNC_READ,
      FUNC_NONE
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP,
      CSR_SOURCE_MASS,
      CSR_COUPLING,
      CSR_DAMPING
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SRC_POS,
      ST_SRC_NEG,
      ST_SWEEP,
      ST_DRAIN,
      ST_FETCH,
      ST_FINISH
   } state_type;

   // control that travels with one cell through the stencil pipeline
   typedef struct packed {
      logic       valid;
      logic       update;
      logic       scale;
      logic [4:0] border_dist;
   } stencil_ctrl_type;

   // largest folded phase with floor(4 cos) >= 3, 2, 1, 0, -1, -2, -3
   localparam logic [15:0] COS_LIMIT [7] = '{
      16'd7538, 16'd10922, 16'd13748, 16'd16384, 16'd19019, 16'd21845, 16'd25229
   };

   // fold a phase into the half turn 0..32768
   function automatic logic [16:0] fold_phase(input logic [PHASE_W-1:0] ph);
      logic [16:0] a;
      a = (ph > 16'd32768) ? (17'd65536 - {1'b0, ph}) : {1'b0, ph};
      return a;
   endfunction

   // floor(4 cos(phase))
   function automatic logic signed [3:0] cos4_floor(input logic [PHASE_W-1:0] ph);
      logic [16:0]       a;
      logic signed [3:0] f;
      a = fold_phase(ph);
      f = -4'sd4;
      for (int k = 6; k >= 0; k--) begin
         if (a <= {1'b0, COS_LIMIT[k]}) begin
            f = 4'sd3 - signed'(4'(k));
         end
      end
      if (a == 17'd0) begin
         f = 4'sd4;
      end
      return f;
   endfunction

   // floor(-4 cos(phase))
   function automatic logic signed [3:0] negcos4_floor(input logic [PHASE_W-1:0] ph);
      logic [16:0]       a;
      logic signed [3:0] f;
      a = fold_phase(ph);
      f = cos4_floor(ph);
      if (a inside {17'd0, 17'd16384, 17'd32768}) begin
         return -f;
      end
      return -f - 4'sd1;
   endfunction

endpackage

// ===== hdl/wgl_ram.sv =====
// wgl_ram: generic simple dual-port memory, one write and one registered read port
// no dependencies

module wgl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/wgl_cell.sv =====
// wgl_cell: one cell of the row buffer, holds one amplitude word and hands it on each cycle
// depends on wgl_pkg

module wgl_cell (
   input  logic                          clock,
   input  logic signed [wgl_pkg::AMP_W-1:0] data_in,
   output logic signed [wgl_pkg::AMP_W-1:0] data_out
);
   import wgl_pkg::*;

   logic signed [AMP_W-1:0] data_ff;

   // shift one position down the chain
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== hdl/wgl_stencil.sv =====
// wgl_stencil: pipelined leapfrog update of one cell per cycle with edge scaling
// depends on wgl_pkg

module wgl_stencil #(
   parameter int AW        = 14,
   parameter int EDGE_BAND = wgl_pkg::EDGE_BAND_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [wgl_pkg::COEF_W-1:0]       coupling,
   input  logic [wgl_pkg::COEF_W-1:0]       damping,
   input  logic signed [wgl_pkg::AMP_W-1:0] tap_c,
   input  logic signed [wgl_pkg::AMP_W-1:0] tap_n,
   input  logic signed [wgl_pkg::AMP_W-1:0] tap_s,
   input  logic signed [wgl_pkg::AMP_W-1:0] tap_e,
   input  logic signed [wgl_pkg::AMP_W-1:0] tap_w,
   input  logic signed [wgl_pkg::AMP_W-1:0] before_val,
   input  wgl_pkg::stencil_ctrl_type        ctrl,
   input  logic [AW-1:0]                    addr,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic signed [wgl_pkg::AMP_W-1:0] wr_data
);
   import wgl_pkg::*;

   localparam int MW = 29;
   localparam int XW = 32;
   localparam int SH = XW + 5;
   localparam int RW = SH + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(EDGE_BAND) - 64'd1) / 64'(EDGE_BAND);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
   localparam logic [MW-1:0] MAG_CLAMP = MW'(1) << 28;
   localparam logic [XW-1:0] HALF_BAND = XW'(EDGE_BAND / 2);

   stencil_ctrl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic            v7_ff;
   logic [AW-1:0]   a1_ff, a2_ff, a3_ff, a4_ff, a5_ff, a6_ff, a7_ff;

   logic signed [26:0] lap_ff;
   logic signed [25:0] diff_ff;
   logic signed [43:0] s_ff;
   logic signed [60:0] p_ff;
   logic [MW-1:0]      m_ff;
   logic               neg4_ff, neg5_ff, neg6_ff;
   logic [XW-1:0]      x5_ff, x6_ff;
   logic [53:0]        pp_hi_ff, pp_lo_ff;
   logic signed [AMP_W-1:0] val_ff;

   logic [60:0]        p_abs;
   logic [60:0]        p_rnd;
   logic [MW-1:0]      m_in;
   logic [XW-1:0]      x_in;
   logic [69:0]        prod;
   logic [32:0]        q;
   logic signed [AMP_W-1:0] val_in;

   // rounding of the damped sum, magnitude clamped where saturation is certain
   always_comb begin
      p_abs = p_ff[60] ? 61'(-p_ff) : 61'(p_ff);
      p_rnd = (p_abs + (61'd1 << 31)) >> 32;
      m_in  = (p_rnd > 61'(MAG_CLAMP)) ? MAG_CLAMP : MW'(p_rnd);
   end

   // distance scale numerator with rounding offset
   always_comb begin
      if (c4_ff.scale) begin
         x_in = XW'(m_ff) * XW'(c4_ff.border_dist) + HALF_BAND;
      end else begin
         x_in = XW'(m_ff);
      end
   end

   // reciprocal divide by the band width, then sign and saturation
   always_comb begin
      prod = (70'(pp_hi_ff) << 16) + 70'(pp_lo_ff);
      q    = c6_ff.scale ? 33'(prod >> SH) : 33'(x6_ff);
      if (neg6_ff) begin
         val_in = (q >= 33'd8388608) ? -24'sd8388608 : -signed'(AMP_W'(q));
      end else begin
         val_in = (q > 33'd8388607) ? 24'sd8388607 : signed'(AMP_W'(q));
      end
   end

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
         v7_ff <= 1'b0;
      end else begin
         c1_ff <= ctrl;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
         v7_ff <= c6_ff.valid & c6_ff.update;
      end
   end

   // address pipeline and arithmetic stages
   always_ff @(posedge clock) begin
      a1_ff    <= addr;
      a2_ff    <= a1_ff;
      a3_ff    <= a2_ff;
      a4_ff    <= a3_ff;
      a5_ff    <= a4_ff;
      a6_ff    <= a5_ff;
      a7_ff    <= a6_ff;
      lap_ff   <= 27'(tap_n) + 27'(tap_s) + 27'(tap_e) + 27'(tap_w) - (27'(tap_c) <<< 2);
      diff_ff  <= (26'(tap_c) <<< 1) - 26'(before_val);
      s_ff     <= (44'(diff_ff) <<< 16) + 44'(signed'({1'b0, coupling})) * 44'(lap_ff);
      p_ff     <= 61'(s_ff) * 61'(signed'({1'b0, damping}));
      m_ff     <= m_in;
      neg4_ff  <= p_ff[60];
      x5_ff    <= x_in;
      neg5_ff  <= neg4_ff;
      x6_ff    <= x5_ff;
      neg6_ff  <= neg5_ff;
      pp_hi_ff <= 54'(x5_ff[31:16]) * 54'(RECIP);
      pp_lo_ff <= 54'(x5_ff[15:0]) * 54'(RECIP);
      val_ff   <= val_in;
   end

   assign wr_en   = v7_ff;
   assign wr_addr = a7_ff;
   assign wr_data = val_ff;

   // a write follows an updating cell by the fixed pipeline length
   a_wr_follows : assert property (@(posedge clock) disable iff (reset)
      (c6_ff.valid && c6_ff.update) |=> wr_en)
      else $error("stencil write lost");

   // edge scaling only applies to cells that are updated
   a_scale_update : assert property (@(posedge clock) disable iff (reset)
      (c1_ff.valid && c1_ff.scale) |-> c1_ff.update)
      else $error("scale flag on non-interior cell");

   // a scaled cell carries a distance below the band width
   a_scale_dist : assert property (@(posedge clock) disable iff (reset)
      (c1_ff.valid && c1_ff.scale) |-> (int'(c1_ff.border_dist) < EDGE_BAND))
      else $error("scale distance out of band");

endmodule

// ===== hdl/wave_grid_leapfrog_step.sv =====
// wave_grid_leapfrog_step: top level, 2D leapfrog wave grid with rotating point sources
// depends on wgl_pkg, wgl_ram, wgl_cell, wgl_stencil
// a tick writes the two source points, sweeps the grid with one grid read per cycle through the
// row buffer chain and drains the stencil pipeline; an in-grid read or interior pulse fetches its
// cell first, other items finish at once; one item at a time, the result strobe lands as busy drops
// after reset a clearing pass zeroes both grids, busy high;
// register writes are taken at all times

module wave_grid_leapfrog_step #(
   parameter int GRID_COLS = wgl_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = wgl_pkg::GRID_ROWS_DEF,
   parameter int EDGE_BAND = wgl_pkg::EDGE_BAND_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [wgl_pkg::FUNC_W-1:0]           req_func,
   input  logic [wgl_pkg::COORD_W-1:0]          req_col,
   input  logic [wgl_pkg::COORD_W-1:0]          req_row,
   output logic                                 rsp_valid,
   output logic signed [wgl_pkg::AMP_W-1:0]     rsp_cell_value,
   output logic                                 rsp_pulse_applied,
   output logic [wgl_pkg::TICK_W-1:0]           rsp_tick_count,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wgl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wgl_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wgl_pkg::*;

   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_COLS);
   localparam int RW    = $clog2(GRID_ROWS + 1);
   localparam int KW    = $clog2(CELLS + GRID_COLS + 1);
   localparam int DW    = $clog2(PIPE_DEPTH + 1);
   localparam int CHAIN = 2 * GRID_COLS;
   localparam logic [KW-1:0] K_LAST = KW'(CELLS + GRID_COLS - 1);

   state_type state_ff, state_in;
   func_type  func_ff;
   logic [COORD_W-1:0] col_ff, row_ff;
   logic [PHASE_W-1:0] phase_ff, phase_step_ff;
   logic [MASS_W-1:0]  mass_ff;
   logic [COEF_W-1:0]  coupling_ff, damping_ff;
   logic [TICK_W-1:0]  ticks_ff;
   logic               sel_ff;
   logic [KW-1:0]      k_ff;
   logic [CW-1:0]      kc_ff;
   logic [RW-1:0]      kr_ff;
   logic [DW-1:0]      drain_ff;
   logic [AW-1:0]      clr_ff;
   stencil_ctrl_type   ctrl_ff, ctrl_in;
   logic [AW-1:0]      caddr_ff, caddr_in;

   logic                    rsp_valid_ff;
   logic signed [AMP_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_applied_ff, rsp_applied_in;
   logic                    rsp_load;

   logic accept;
   logic req_interior, req_in_grid, lat_interior, lat_in_grid;
   logic [AW-1:0] item_addr;
   logic sweep_done, drain_done, clear_done;

   logic                    now_we, bef_we, clear_we;
   logic [AW-1:0]           now_waddr, now_raddr, bef_waddr, bef_raddr;
   logic signed [AMP_W-1:0] now_wdata, bef_wdata, now_rdata, bef_rdata;
   logic signed [AMP_W-1:0] pulse_sum;
   logic signed [25:0]      pulse_wide;

   logic                    a_we, b_we;
   logic [AW-1:0]           a_waddr, b_waddr, a_raddr, b_raddr;
   logic signed [AMP_W-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

   logic signed [AMP_W-1:0] chain_q [CHAIN];

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // item position checks
   assign req_interior = (int'(req_col) > 0) && (int'(req_col) < GRID_COLS - 1)
                      && (int'(req_row) > 0) && (int'(req_row) < GRID_ROWS - 1);
   assign req_in_grid  = (int'(req_col) < GRID_COLS) && (int'(req_row) < GRID_ROWS);
   assign lat_interior = (int'(col_ff) > 0) && (int'(col_ff) < GRID_COLS - 1)
                      && (int'(row_ff) > 0) && (int'(row_ff) < GRID_ROWS - 1);
   assign lat_in_grid  = (int'(col_ff) < GRID_COLS) && (int'(row_ff) < GRID_ROWS);
   assign item_addr    = AW'(int'(row_ff) * GRID_COLS + int'(col_ff));

   assign sweep_done = (k_ff == K_LAST);
   assign drain_done = (drain_ff == DW'(PIPE_DEPTH - 1));
   assign clear_done = (clr_ff == AW'(CELLS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (func_type'(req_func) == FUNC_TICK) begin
                  state_in = ST_SRC_POS;
               end else if ((func_type'(req_func) == FUNC_PULSE && req_interior)
                         || (func_type'(req_func) == FUNC_READ && req_in_grid)) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SRC_POS: state_in = ST_SRC_NEG;
         ST_SRC_NEG: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (sweep_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_done) state_in = ST_IDLE;
         end
         ST_FETCH:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // pulse add with saturation
   assign pulse_wide = 26'(now_rdata) + signed'(26'({mass_ff, 1'b0}));
   assign pulse_sum  = (pulse_wide > 26'sd8388607) ? 24'sd8388607 : AMP_W'(pulse_wide);

   // memory control, sweep issue and result
   always_comb begin
      logic signed [3:0] fc, fr;
      int src_c, src_r, ci, cj, d;
      now_we         = 1'b0;
      now_waddr      = item_addr;
      now_wdata      = pulse_sum;
      now_raddr      = item_addr;
      bef_raddr      = '0;
      clear_we       = (state_ff == ST_CLEAR);
      ctrl_in        = '0;
      caddr_in       = '0;
      rsp_load       = 1'b0;
      rsp_value_in   = '0;
      rsp_applied_in = 1'b0;
      fc    = '0;
      fr    = '0;
      ci    = int'(kc_ff);
      cj    = int'(kr_ff) - 1;
      d     = ci;
      if (GRID_COLS - 1 - ci < d) d = GRID_COLS - 1 - ci;
      if (cj < d) d = cj;
      if (GRID_ROWS - 1 - cj < d) d = GRID_ROWS - 1 - cj;
      case (state_ff)
         ST_SRC_POS: begin
            fc = cos4_floor(phase_ff);
            fr = cos4_floor(phase_ff - 16'd16384);
         end
         ST_SRC_NEG: begin
            fc = negcos4_floor(phase_ff);
            fr = negcos4_floor(phase_ff - 16'd16384);
         end
         default: begin
            fc = '0;
            fr = '0;
         end
      endcase
      src_c = GRID_COLS / 2 + int'(fc);
      src_r = GRID_ROWS / 2 + int'(fr);
      case (state_ff)
         ST_SRC_POS, ST_SRC_NEG: begin
            now_we    = (src_c > 0) && (src_c < GRID_COLS - 1)
                     && (src_r > 0) && (src_r < GRID_ROWS - 1);
            now_waddr = AW'(src_r * GRID_COLS + src_c);
            now_wdata = (state_ff == ST_SRC_POS) ? signed'(AMP_W'(mass_ff))
                                                 : -signed'(AMP_W'(mass_ff));
         end
         ST_SWEEP: begin
            now_raddr      = (k_ff < KW'(CELLS)) ? AW'(k_ff) : '0;
            bef_raddr      = (k_ff >= KW'(GRID_COLS)) ? AW'(k_ff - KW'(GRID_COLS)) : '0;
            caddr_in       = bef_raddr;
            ctrl_in.valid  = 1'b1;
            ctrl_in.update = (ci > 0) && (ci < GRID_COLS - 1)
                          && (cj > 0) && (cj < GRID_ROWS - 1);
            ctrl_in.scale  = ctrl_in.update && (d < EDGE_BAND);
            ctrl_in.border_dist = 5'(d);
         end
         ST_DRAIN: begin
            rsp_load = drain_done;
         end
         ST_FINISH: begin
            rsp_load       = 1'b1;
            now_we         = (func_ff == FUNC_PULSE) && lat_interior;
            rsp_applied_in = (func_ff == FUNC_PULSE) && lat_interior;
            rsp_value_in   = ((func_ff == FUNC_READ) && lat_in_grid) ? now_rdata : '0;
         end
         default: begin
            now_we = 1'b0;
         end
      endcase
   end

   // bank steering: sel picks which bank holds the current grid
   always_comb begin
      a_we    = clear_we || (sel_ff ? bef_we : now_we);
      b_we    = clear_we || (sel_ff ? now_we : bef_we);
      a_waddr = clear_we ? clr_ff : (sel_ff ? bef_waddr : now_waddr);
      b_waddr = clear_we ? clr_ff : (sel_ff ? now_waddr : bef_waddr);
      a_wdata = clear_we ? '0 : (sel_ff ? bef_wdata : now_wdata);
      b_wdata = clear_we ? '0 : (sel_ff ? now_wdata : bef_wdata);
      a_raddr = sel_ff ? bef_raddr : now_raddr;
      b_raddr = sel_ff ? now_raddr : bef_raddr;
   end

   assign now_rdata = sel_ff ? b_rdata : a_rdata;
   assign bef_rdata = sel_ff ? a_rdata : b_rdata;

   wgl_ram #(.WIDTH(AMP_W), .DEPTH(CELLS)) u_bank_a (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (a_wdata),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   wgl_ram #(.WIDTH(AMP_W), .DEPTH(CELLS)) u_bank_b (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   // row buffer: two grid rows of cells behind the read port
   for (genvar p = 0; p < CHAIN; p++) begin : g_chain
      if (p == 0) begin : g_head
         wgl_cell u_cell (.clock(clock), .data_in(now_rdata), .data_out(chain_q[p]));
      end else begin : g_body
         wgl_cell u_cell (.clock(clock), .data_in(chain_q[p-1]), .data_out(chain_q[p]));
      end
   end

   wgl_stencil #(.AW(AW), .EDGE_BAND(EDGE_BAND)) u_stencil (
      .clock      (clock),
      .reset      (reset),
      .coupling   (coupling_ff),
      .damping    (damping_ff),
      .tap_c      (chain_q[GRID_COLS-1]),
      .tap_n      (chain_q[CHAIN-1]),
      .tap_s      (now_rdata),
      .tap_e      (chain_q[GRID_COLS-2]),
      .tap_w      (chain_q[GRID_COLS]),
      .before_val (bef_rdata),
      .ctrl       (ctrl_ff),
      .addr       (caddr_ff),
      .wr_en      (bef_we),
      .wr_addr    (bef_waddr),
      .wr_data    (bef_wdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sel_ff        <= 1'b0;
         phase_ff      <= '0;
         ticks_ff      <= '0;
         clr_ff        <= '0;
         k_ff          <= '0;
         kc_ff         <= '0;
         kr_ff         <= '0;
         drain_ff      <= '0;
         ctrl_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         phase_step_ff <= PHASE_STEP_RST;
         mass_ff       <= MASS_RST;
         coupling_ff   <= COUPLING_RST;
         damping_ff    <= DAMPING_RST;
      end else begin
         state_ff     <= state_in;
         ctrl_ff      <= ctrl_in;
         rsp_valid_ff <= rsp_load;
         if (clear_we) clr_ff <= clr_ff + AW'(1);
         if (accept) begin
            k_ff     <= '0;
            kc_ff    <= '0;
            kr_ff    <= '0;
            drain_ff <= '0;
            if (func_type'(req_func) == FUNC_TICK) begin
               phase_ff <= phase_ff + phase_step_ff;
               ticks_ff <= ticks_ff + TICK_W'(1);
            end
         end
         if (state_ff == ST_SWEEP) begin
            k_ff <= k_ff + KW'(1);
            if (kc_ff == CW'(GRID_COLS - 1)) begin
               kc_ff <= '0;
               kr_ff <= kr_ff + RW'(1);
            end else begin
               kc_ff <= kc_ff + CW'(1);
            end
         end
         if (state_ff == ST_DRAIN) begin
            drain_ff <= drain_ff + DW'(1);
            if (drain_done) sel_ff <= ~sel_ff;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PHASE_STEP:  phase_step_ff <= PHASE_W'(csr_wdata);
               CSR_SOURCE_MASS: mass_ff       <= csr_wdata;
               CSR_COUPLING:    coupling_ff   <= COEF_W'(csr_wdata);
               CSR_DAMPING:     damping_ff    <= COEF_W'(csr_wdata);
               default:         mass_ff       <= mass_ff;
            endcase
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      caddr_ff <= caddr_in;
      if (accept) begin
         func_ff <= func_type'(req_func);
         col_ff  <= req_col;
         row_ff  <= req_row;
      end
      if (rsp_load) begin
         rsp_value_ff   <= rsp_value_in;
         rsp_applied_ff <= rsp_applied_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_pulse_applied = rsp_applied_ff;
   assign rsp_tick_count    = ticks_ff;

   // one result word per item, never two in a row
   a_single_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   // a result only closes out work in progress
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item");

   // stencil writes land only while a tick is sweeping or draining
   a_sweep_write : assert property (@(posedge clock) disable iff (reset)
      bef_we |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("stencil write outside a tick");

   // the tick counter moves only for an accepted tick
   a_tick_count : assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && (ticks_ff != $past(ticks_ff)))
         |-> $past(accept && func_type'(req_func) == FUNC_TICK))
      else $error("tick count moved without a tick");

   // the sweep never issues past the flush of the last row
   a_sweep_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (k_ff <= K_LAST))
      else $error("sweep counter overran");

endmodule
